// File: rtl/dpd_pkg.sv
// ----------------------------------------------------------------------------
// dpd_pkg: shared types and constants of the debug packet deframer
// Framing characters, event codes and the body length limit.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam int unsigned MAX_BODY  = 4096;
  localparam int unsigned COUNT_MAX = 8191;
  localparam int unsigned LIMIT_INT = (MAX_BODY > COUNT_MAX) ? COUNT_MAX : MAX_BODY;
  localparam logic [12:0] BODY_LIMIT = LIMIT_INT[12:0];

  localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
  localparam logic [7:0] CH_BREAK = 8'h03;
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [3:0] HEX_TEN  = 4'hA;

  typedef enum logic [2:0] {
    EV_BODY     = 3'd0,
    EV_ACK      = 3'd1,
    EV_NACK_SUM = 3'd2,
    EV_NACK_OVF = 3'd3,
    EV_BREAK    = 3'd4
  } event_t;

endpackage

// File: rtl/dpd_in_if.sv
// ----------------------------------------------------------------------------
// dpd_in_if: received byte channel
// valid/ready channel carrying one byte from the debug link.
// ----------------------------------------------------------------------------
interface dpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/dpd_out_if.sv
// ----------------------------------------------------------------------------
// dpd_out_if: deframer event channel
// valid/ready channel carrying one event with its packet status.
// ----------------------------------------------------------------------------
interface dpd_out_if
  import dpd_pkg::*;
;
  logic        valid;
  logic        ready;
  event_t      event_res;
  logic [7:0]  body_byte;
  logic [12:0] payload_length;
  logic [7:0]  sum_computed;
  logic [7:0]  sum_received;

  modport source (output valid, output event_res, output body_byte,
                  output payload_length, output sum_computed, output sum_received,
                  input ready);
  modport sink (input valid, input event_res, input body_byte,
                input payload_length, input sum_computed, input sum_received,
                output ready);
endinterface

// File: rtl/debug_packet_deframer.sv
// ----------------------------------------------------------------------------
// debug_packet_deframer: "$body#hh" packet receiver for a debug link
// Passes body bytes out, checks the modulo 256 checksum, reports breaks and overflows.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_rx     in   rx_byte
//  out_ev    out  event_res, body_byte, payload_length, sum_computed,
//                 sum_received
//
//  one byte per cycle: the state update and event are one short pass of
//  logic into the event register, so a byte is taken every cycle while the
//  event register is empty or being drained in the same cycle.
//  the event appears in the cycle after its byte is taken; '$', '#' and the
//  first hex digit make no event.
//  synchronous active-low reset returns to idle with an empty event register.
//  a stalled out_ev holds its event and stops in_rx only while it is full.
// ----------------------------------------------------------------------------
module debug_packet_deframer
  import dpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  dpd_in_if.sink     in_rx,
  dpd_out_if.source  out_ev
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_HEX1 = 2'd2,
    PH_HEX2 = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [12:0] count_r, count_nxt;
  logic [3:0]  high_r, high_nxt;

  logic        valid_r, valid_nxt;
  event_t      ev_r, ev_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [12:0] len_r, len_nxt;
  logic [7:0]  csum_r, csum_nxt;
  logic [7:0]  rcv_r, rcv_nxt;

  logic        accept;
  logic        emit;
  logic [7:0]  c;
  logic [7:0]  rcv;
  logic [7:0]  sum_add;
  logic [12:0] count_inc;

  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [3:0] v;
    v = 4'h0;
    if (ch >= 8'h30 && ch <= 8'h39) v = ch[3:0];
    else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46))
      v = ch[3:0] - 4'h1 + HEX_TEN;
    return v;
  endfunction

  assign in_rx.ready = !valid_r || out_ev.ready;
  assign accept      = in_rx.valid && in_rx.ready;
  assign c           = in_rx.rx_byte;
  assign rcv         = {high_r, hex_value(c)};
  assign sum_add     = sum_r + c;
  assign count_inc   = count_r + 13'd1;

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    high_nxt  = high_r;
    emit      = 1'b0;
    ev_nxt    = EV_BODY;
    byte_nxt  = 8'h00;
    len_nxt   = 13'd0;
    csum_nxt  = 8'h00;
    rcv_nxt   = 8'h00;
    unique case (phase_r)
      PH_IDLE: begin
        if (c == CH_BREAK) begin
          emit   = 1'b1;
          ev_nxt = EV_BREAK;
        end else if (c == CH_START) begin
          sum_nxt   = 8'h00;
          count_nxt = 13'd0;
          high_nxt  = 4'h0;
          phase_nxt = PH_BODY;
        end
        // '+' and stray bytes fall through silently
      end
      PH_BODY: begin
        if (c == CH_END) begin
          phase_nxt = PH_HEX1;
        end else if (count_r >= BODY_LIMIT) begin
          emit      = 1'b1;
          ev_nxt    = EV_NACK_OVF;
          len_nxt   = count_r;
          csum_nxt  = sum_r;
          phase_nxt = PH_IDLE;
        end else begin
          emit      = 1'b1;
          count_nxt = count_inc;
          sum_nxt   = sum_add;
          byte_nxt  = c;
          len_nxt   = count_inc;
          csum_nxt  = sum_add;
        end
      end
      PH_HEX1: begin
        high_nxt  = hex_value(c);
        phase_nxt = PH_HEX2;
      end
      PH_HEX2: begin
        emit      = 1'b1;
        ev_nxt    = (rcv == sum_r) ? EV_ACK : EV_NACK_SUM;
        len_nxt   = count_r;
        csum_nxt  = sum_r;
        rcv_nxt   = rcv;
        phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase

    if (accept) valid_nxt = emit;
    else if (out_ev.ready) valid_nxt = 1'b0;
    else valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sum_r   <= 8'h00;
      count_r <= 13'd0;
      high_r  <= 4'h0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
        high_r  <= high_nxt;
      end
    end
    // event payload needs no reset
    if (accept && emit) begin
      ev_r   <= ev_nxt;
      byte_r <= byte_nxt;
      len_r  <= len_nxt;
      csum_r <= csum_nxt;
      rcv_r  <= rcv_nxt;
    end
  end

  assign out_ev.valid          = valid_r;
  assign out_ev.event_res      = ev_r;
  assign out_ev.body_byte      = byte_r;
  assign out_ev.payload_length = len_r;
  assign out_ev.sum_computed   = csum_r;
  assign out_ev.sum_received   = rcv_r;

  // a break carries no packet status
  a_break_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && ev_r == EV_BREAK) |-> (len_r == 13'd0 && csum_r == 8'h00))
    else $error("break event with nonzero status");

  // a body byte is always counted and never past the limit
  a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && ev_r == EV_BODY) |-> (len_r != 13'd0 && len_r <= BODY_LIMIT))
    else $error("body event length out of range");

  // ack and checksum nack agree with the compared sums
  a_ack_match: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && ev_r == EV_ACK) |-> (rcv_r == csum_r))
    else $error("ack with mismatched checksum");

  a_nack_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && ev_r == EV_NACK_SUM) |-> (rcv_r != csum_r))
    else $error("checksum nack with matching checksum");

  // a full, stalled event register blocks the input side
  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ev.ready) |-> !in_rx.ready)
    else $error("input taken while event register is stalled");

endmodule

// File: test/dpd_checker.sv
// ----------------------------------------------------------------------------
// dpd_checker: event checker of the debug packet deframer
// Watches both channels, runs its own deframer on every accepted byte and
// compares each accepted event field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dpd_checker
  import dpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dpd_in_if    in_mon,
  dpd_out_if   out_mon,
  output int   mismatch_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_HEX1 = 2'd2,
    PH_HEX2 = 2'd3
  } phase_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  body;
    logic [12:0] len;
    logic [7:0]  sum;
    logic [7:0]  rcv;
  } event_rec_t;

  phase_t      phase;
  logic [7:0]  running_sum;
  logic [12:0] body_count;
  logic [3:0]  high_nibble;
  event_rec_t  pending_events[$];

  // anything outside 0-9, a-f, A-F decodes as zero
  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + HEX_TEN;
    else if (c >= "A" && c <= "F") v = c - "A" + HEX_TEN;
    return v[3:0];
  endfunction

  task automatic deframe_byte(input logic [7:0] c);
    logic [7:0] rcv;
    event_t     ev;
    case (phase)
      PH_IDLE: begin
        if (c == CH_BREAK) begin
          pending_events.push_back('{EV_BREAK, 8'h00, 13'd0, 8'h00, 8'h00});
        end else if (c == CH_START) begin
          running_sum = 8'h00;
          body_count  = 13'd0;
          high_nibble = 4'h0;
          phase       = PH_BODY;
        end
      end
      PH_BODY: begin
        if (c == CH_END) begin
          phase = PH_HEX1;
        end else if (body_count >= BODY_LIMIT) begin
          // overflowing byte is dropped, packet abandoned
          pending_events.push_back('{EV_NACK_OVF, 8'h00, body_count, running_sum, 8'h00});
          phase = PH_IDLE;
        end else begin
          body_count  = body_count + 13'd1;
          running_sum = running_sum + c;
          pending_events.push_back('{EV_BODY, c, body_count, running_sum, 8'h00});
        end
      end
      PH_HEX1: begin
        high_nibble = hex_nibble(c);
        phase       = PH_HEX2;
      end
      default: begin
        rcv = {high_nibble, hex_nibble(c)};
        if (rcv == running_sum) ev = EV_ACK;
        else ev = EV_NACK_SUM;
        pending_events.push_back('{ev, 8'h00, body_count, running_sum, rcv});
        phase = PH_IDLE;
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    event_rec_t exp_ev;
    if (!rst_n) begin
      phase       = PH_IDLE;
      running_sum = 8'h00;
      body_count  = 13'd0;
      high_nibble = 4'h0;
      pending_events.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) deframe_byte(in_mon.rx_byte);
      if (out_mon.valid && out_mon.ready) begin
        if (pending_events.size() == 0) begin
          $error("event_res: expected none, actual %0d", out_mon.event_res);
          mismatch_count++;
        end else begin
          exp_ev = pending_events.pop_front();
          check_field("event_res", 32'(exp_ev.ev), 32'(out_mon.event_res));
          check_field("body_byte", 32'(exp_ev.body), 32'(out_mon.body_byte));
          check_field("payload_length", 32'(exp_ev.len), 32'(out_mon.payload_length));
          check_field("sum_computed", 32'(exp_ev.sum), 32'(out_mon.sum_computed));
          check_field("sum_received", 32'(exp_ev.rcv), 32'(out_mon.sum_received));
        end
      end
    end
    outstanding <= pending_events.size();
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top of the debug packet deframer
// Drives received bytes with random gaps and random event back-pressure:
// framing corner cases, one overflowing and one full-size packet, then
// mostly well-formed random packets mixed with breaks, noise and broken
// frames. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import dpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1000;
  localparam int IDLE_PCT     = 34;
  localparam int DRAIN_CYCLES = 8;
  // roughly 10k bytes in a correct run
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   cycle_count;
  int   mismatch_count;
  int   outstanding;

  dpd_in_if  in_rx();
  dpd_out_if out_ev();

  debug_packet_deframer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_rx  (in_rx),
    .out_ev (out_ev)
  );

  dpd_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_rx),
    .out_mon        (out_ev),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ev.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_rx.valid <= 1'b0;
      @(negedge clk);
    end
    in_rx.valid   <= 1'b1;
    in_rx.rx_byte <= b;
    do @(posedge clk); while (!in_rx.ready);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < HEX_TEN) return "0" + n;
    return (upper ? "A" : "a") + n - HEX_TEN;
  endfunction

  function automatic logic [7:0] body_sum(byte_q_t body);
    logic [7:0] s;
    s = 8'h00;
    foreach (body[i]) s = s + body[i];
    return s;
  endfunction

  // random body bytes, never the closing character
  function automatic byte_q_t random_body(int len);
    byte_q_t    q;
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (b == CH_END) b = ~b;
      q.push_back(b);
    end
    return q;
  endfunction

  task automatic send_packet(input byte_q_t body, input logic [7:0] hi, input logic [7:0] lo);
    send_byte(CH_START);
    foreach (body[i]) send_byte(body[i]);
    send_byte(CH_END);
    send_byte(hi);
    send_byte(lo);
  endtask

  initial begin
    byte_q_t    body;
    logic [7:0] sum;
    logic [7:0] hi;
    logic [7:0] lo;
    int         kind;
    int         len;
    int         random_items;

    rst_n         = 1'b0;
    no_idle       = 1'b0;
    in_rx.valid   = 1'b0;
    in_rx.rx_byte = 8'h00;
    out_ev.ready  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle bytes: break, ack char, strays
    send_byte(CH_BREAK);
    send_byte(CH_ACK);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_END);
    // empty packet
    body.delete();
    send_packet(body, "0", "0");
    // framing characters inside a body are data
    body = {CH_BREAK, CH_ACK, CH_START, 8'hFF};
    send_packet(body, "5", "3");
    // mixed case hex digits
    body = {8'hAB};
    send_packet(body, "a", "B");
    // non-hex digits decode as zero
    body = {8'h01};
    send_packet(body, "g", "1");
    body = {8'h10};
    send_packet(body, "1", "/");
    // checksum mismatch
    body = {8'h55};
    send_packet(body, "0", "0");

    // overflow: the extra byte is dropped and the trailer is idle noise
    body = random_body(int'(BODY_LIMIT));
    send_byte(CH_START);
    foreach (body[i]) send_byte(body[i]);
    send_byte(CH_START);
    send_byte(CH_END);
    send_byte("4");
    send_byte("1");
    // full-size packet closes normally
    body = random_body(int'(BODY_LIMIT));
    sum  = body_sum(body);
    send_packet(body, hex_char(sum[7:4], 1'b1), hex_char(sum[3:0], 1'b0));

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      no_idle = (random_items >= 400 && random_items < 550);
      kind    = $urandom_range(99);
      len     = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
      body    = random_body(len);
      if (kind < 70) begin
        sum = body_sum(body);
        if ($urandom_range(99) < 40) sum = 8'($urandom);
        hi = hex_char(sum[7:4], 1'($urandom_range(1)));
        lo = hex_char(sum[3:0], 1'($urandom_range(1)));
        if ($urandom_range(9) == 0) hi = 8'($urandom);
        if ($urandom_range(9) == 0) lo = 8'($urandom);
        send_packet(body, hi, lo);
        random_items += len + 4;
      end else if (kind < 78) begin
        send_byte(CH_BREAK);
        random_items += 1;
      end else if (kind < 86) begin
        send_byte(8'($urandom));
      end else if (kind < 93) begin
        // unterminated body runs into whatever comes next
        send_byte(CH_START);
        foreach (body[i]) send_byte(body[i]);
        random_items += len + 1;
      end else begin
        send_packet(body, 8'($urandom), 8'($urandom));
        random_items += len + 4;
      end
    end
    no_idle = 1'b0;

    @(negedge clk);
    in_rx.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
